// File: src/tlmt_pkg.sv
// Shared types and codes of the two-level membership table.
package tlmt_pkg;

    // Fixed widths of the request and response fields.
    localparam int MODE_W   = 3;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // Operation codes.
    localparam mode_t MODE_ADD_GROUP   = 3'd0;
    localparam mode_t MODE_ADD_MEMBER  = 3'd1;
    localparam mode_t MODE_FIND_GROUP  = 3'd2;
    localparam mode_t MODE_FIND_MEMBER = 3'd3;
    localparam mode_t MODE_COUNT       = 3'd4;
    localparam mode_t MODE_DEL_MEMBER  = 3'd5;
    localparam mode_t MODE_PURGE       = 3'd6;
    localparam mode_t MODE_DEL_GROUP   = 3'd7;

    // Response status codes.
    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_NOT_FOUND   = 3'd1;
    localparam status_t ST_TABLE_EMPTY = 3'd2;
    localparam status_t ST_LIST_EMPTY  = 3'd3;
    localparam status_t ST_FULL        = 3'd4;

    // Saturation value of the match counter.
    localparam count_t COUNT_MAX = 9'd511;

endpackage

// File: src/tlmt_ifs.sv
// Request and response channel interfaces of the membership table.
interface tlmt_req_if;
    import tlmt_pkg::*;

    logic  valid;
    logic  ready;
    mode_t mode;
    key_t  group_key;
    key_t  member_key;

    modport source (output valid, output mode, output group_key, output member_key,
                    input ready);
    modport sink (input valid, input mode, input group_key, input member_key,
                  output ready);
endinterface

interface tlmt_rsp_if;
    import tlmt_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    count_t  match_count;

    modport source (output valid, output status, output match_count, input ready);
    modport sink (input valid, input status, input match_count, output ready);
endinterface

// File: src/two_level_membership_table_top.sv
// Two-level membership table: group list and per-group member lists in memories.
// An append group or an empty-table answer goes from accept straight to the finish state.
// Scans read each group visited and each member compared through the registered read
// ports of the group and member memories; a deletion also moves each later entry down,
// and a member deletion rewrites the member count. Requests are taken one at a time;
// a finished response waits in an output register.
// Reset clears the group count and the control state; memory contents need no clearing.
module two_level_membership_table_top #(
    parameter int MAX_GROUPS            = 16,
    parameter int MAX_MEMBERS_PER_GROUP = 16,
    parameter int KEY_BITS              = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tlmt_req_if.sink   req,
    tlmt_rsp_if.source rsp
);
    import tlmt_pkg::*;

    localparam int GCW = $clog2(MAX_GROUPS + 1);
    localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int MCW = $clog2(MAX_MEMBERS_PER_GROUP + 1);
    localparam int MW  = (MAX_MEMBERS_PER_GROUP > 1) ? $clog2(MAX_MEMBERS_PER_GROUP) : 1;
    localparam int KW  = KEY_BITS;
    localparam int EW  = KW + MCW;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_G_RD   = 4'd1;
    localparam logic [3:0] S_G_CHK  = 4'd2;
    localparam logic [3:0] S_M_RD   = 4'd3;
    localparam logic [3:0] S_M_CHK  = 4'd4;
    localparam logic [3:0] S_MS_RD  = 4'd5;
    localparam logic [3:0] S_MS_WR  = 4'd6;
    localparam logic [3:0] S_MS_END = 4'd7;
    localparam logic [3:0] S_GS_RD  = 4'd8;
    localparam logic [3:0] S_GS_WR  = 4'd9;
    localparam logic [3:0] S_RC_RD  = 4'd10;
    localparam logic [3:0] S_RC_WR  = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    // Memories: group entries hold {key, member count}; member keys by row and column.
    logic [EW-1:0] gmem [MAX_GROUPS];
    logic [KW-1:0] mmem [MAX_GROUPS][MAX_MEMBERS_PER_GROUP];
    logic [EW-1:0] g_q;
    logic [KW-1:0] m_q;

    logic [3:0]     state_reg, state_next;
    mode_t          mode_reg, mode_next;
    logic [KW-1:0]  gk_reg, gk_next;
    logic [KW-1:0]  mk_reg, mk_next;
    logic [GCW-1:0] used_reg, used_next;
    logic [GCW-1:0] g_reg, g_next;
    logic [MCW-1:0] i_reg, i_next;
    logic [MCW-1:0] j_reg, j_next;
    logic [MCW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0]  key_cur_reg, key_cur_next;
    status_t        status_reg, status_next;
    count_t         count_reg, count_next;
    logic           rsp_valid_reg;
    status_t        rsp_status_reg;
    count_t         rsp_count_reg;
    logic           rsp_load;

    logic           g_we, m_we;
    logic [GW-1:0]  g_wa, g_ra, m_wr, m_rr;
    logic [MW-1:0]  m_wc, m_rc;
    logic [EW-1:0]  g_wd;
    logic [KW-1:0]  m_wd;

    logic [GW-1:0]  g_idx, g_idx_p1;
    logic [KW-1:0]  q_key;
    logic [MCW-1:0] q_cnt;
    logic           last_group;
    logic           accept;

    assign g_idx      = g_reg[GW-1:0];
    assign g_idx_p1   = GW'(g_reg + GCW'(1));
    assign q_key      = g_q[EW-1:MCW];
    assign q_cnt      = g_q[MCW-1:0];
    assign last_group = ((g_reg + GCW'(1)) == used_reg);
    assign accept     = req.valid && req.ready;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.match_count = rsp_count_reg;

    // Memory ports: one write and one registered read per memory each cycle.
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gmem[g_wa] <= g_wd;
        end
        if (m_we)
        begin
            mmem[m_wr][m_wc] <= m_wd;
        end
        g_q <= gmem[g_ra];
        m_q <= mmem[m_rr][m_rc];
    end

    // Read address selection.
    always_comb
    begin
        g_ra = (state_reg == S_GS_RD) ? g_idx_p1 : g_idx;
        m_rr = (state_reg == S_RC_RD) ? g_idx_p1 : g_idx;
        case (state_reg)
            S_MS_RD: m_rc = MW'(j_reg + MCW'(1));
            S_RC_RD: m_rc = j_reg[MW-1:0];
            default: m_rc = i_reg[MW-1:0];
        endcase
    end

    // Sequencer: walks groups and members, modifies and writes back.
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        gk_next      = gk_reg;
        mk_next      = mk_reg;
        used_next    = used_reg;
        g_next       = g_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        key_cur_next = key_cur_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        rsp_load     = 1'b0;
        g_we         = 1'b0;
        g_wa         = g_idx;
        g_wd         = g_q;
        m_we         = 1'b0;
        m_wr         = g_idx;
        m_wc         = j_reg[MW-1:0];
        m_wd         = m_q;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = req.mode;
                    gk_next     = KW'(req.group_key);
                    mk_next     = KW'(req.member_key);
                    count_next  = '0;
                    status_next = ST_NOT_FOUND;
                    g_next      = '0;
                    if (req.mode == MODE_ADD_GROUP)
                    begin
                        state_next = S_FIN;
                        if (used_reg == GCW'(MAX_GROUPS))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            g_we        = 1'b1;
                            g_wa        = used_reg[GW-1:0];
                            g_wd        = {KW'(req.group_key), MCW'(0)};
                            used_next   = used_reg + GCW'(1);
                            status_next = ST_OK;
                        end
                    end
                    else if (used_reg == '0)
                    begin
                        status_next = ST_TABLE_EMPTY;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_G_RD;
                    end
                end
            end

            S_G_RD:
            begin
                state_next = S_G_CHK;
            end

            S_G_CHK:
            begin
                key_cur_next = q_key;
                cnt_next     = q_cnt;
                i_next       = '0;
                j_next       = '0;
                if ((q_key == gk_reg) && (mode_reg == MODE_ADD_MEMBER))
                begin
                    state_next = S_FIN;
                    if (q_cnt == MCW'(MAX_MEMBERS_PER_GROUP))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        m_we        = 1'b1;
                        m_wc        = q_cnt[MW-1:0];
                        m_wd        = mk_reg;
                        g_we        = 1'b1;
                        g_wd        = {q_key, q_cnt + MCW'(1)};
                    end
                end
                else if ((q_key == gk_reg) && (mode_reg == MODE_FIND_GROUP))
                begin
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
                else if ((q_key == gk_reg) && (mode_reg == MODE_DEL_GROUP))
                begin
                    status_next = ST_OK;
                    if (last_group)
                    begin
                        used_next  = used_reg - GCW'(1);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_GS_RD;
                    end
                end
                else if ((q_key == gk_reg) && (q_cnt == '0) &&
                         ((mode_reg == MODE_FIND_MEMBER) || (mode_reg == MODE_DEL_MEMBER)))
                begin
                    status_next = ST_LIST_EMPTY;
                    state_next  = S_FIN;
                end
                else if ((q_cnt != '0) &&
                         (((q_key == gk_reg) && ((mode_reg == MODE_FIND_MEMBER) ||
                                                 (mode_reg == MODE_DEL_MEMBER))) ||
                          (mode_reg == MODE_COUNT) || (mode_reg == MODE_PURGE)))
                begin
                    state_next = S_M_RD;
                end
                else if (last_group)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    g_next     = g_reg + GCW'(1);
                    state_next = S_G_RD;
                end
            end

            S_M_RD:
            begin
                state_next = S_M_CHK;
            end

            S_M_CHK:
            begin
                j_next = i_reg;
                if ((m_q == mk_reg) && (mode_reg == MODE_FIND_MEMBER))
                begin
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
                else if ((m_q == mk_reg) &&
                         ((mode_reg == MODE_DEL_MEMBER) || (mode_reg == MODE_PURGE)))
                begin
                    status_next = ST_OK;
                    // Only a purge reports how many entries it removed.
                    if ((mode_reg == MODE_PURGE) && (count_reg != COUNT_MAX))
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if ((i_reg + MCW'(1)) < cnt_reg)
                    begin
                        state_next = S_MS_RD;
                    end
                    else
                    begin
                        state_next = S_MS_END;
                    end
                end
                else
                begin
                    if ((m_q == mk_reg) && (count_reg != COUNT_MAX))
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if ((i_reg + MCW'(1)) != cnt_reg)
                    begin
                        i_next     = i_reg + MCW'(1);
                        state_next = S_M_RD;
                    end
                    else if (last_group)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        g_next     = g_reg + GCW'(1);
                        state_next = S_G_RD;
                    end
                end
            end

            S_MS_RD:
            begin
                state_next = S_MS_WR;
            end

            // Close the gap: entry j takes entry j + 1.
            S_MS_WR:
            begin
                m_we   = 1'b1;
                m_wc   = j_reg[MW-1:0];
                m_wd   = m_q;
                j_next = j_reg + MCW'(1);
                if (({1'b0, j_reg} + (MCW+1)'(2)) < {1'b0, cnt_reg})
                begin
                    state_next = S_MS_RD;
                end
                else
                begin
                    state_next = S_MS_END;
                end
            end

            S_MS_END:
            begin
                g_we     = 1'b1;
                g_wd     = {key_cur_reg, cnt_reg - MCW'(1)};
                cnt_next = cnt_reg - MCW'(1);
                if (mode_reg == MODE_DEL_MEMBER)
                begin
                    state_next = S_FIN;
                end
                else if (i_reg < (cnt_reg - MCW'(1)))
                begin
                    state_next = S_M_RD;
                end
                else if (last_group)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    g_next     = g_reg + GCW'(1);
                    state_next = S_G_RD;
                end
            end

            S_GS_RD:
            begin
                state_next = S_GS_WR;
            end

            // Move group entry g + 1 down to g, then copy its member row.
            S_GS_WR:
            begin
                g_we     = 1'b1;
                g_wd     = g_q;
                cnt_next = q_cnt;
                j_next   = '0;
                if (q_cnt != '0)
                begin
                    state_next = S_RC_RD;
                end
                else if ((g_reg + GCW'(2)) < used_reg)
                begin
                    g_next     = g_reg + GCW'(1);
                    state_next = S_GS_RD;
                end
                else
                begin
                    used_next  = used_reg - GCW'(1);
                    state_next = S_FIN;
                end
            end

            S_RC_RD:
            begin
                state_next = S_RC_WR;
            end

            S_RC_WR:
            begin
                m_we   = 1'b1;
                m_wc   = j_reg[MW-1:0];
                m_wd   = m_q;
                j_next = j_reg + MCW'(1);
                if ((j_reg + MCW'(1)) != cnt_reg)
                begin
                    state_next = S_RC_RD;
                end
                else if ((g_reg + GCW'(2)) < used_reg)
                begin
                    g_next     = g_reg + GCW'(1);
                    state_next = S_GS_RD;
                end
                else
                begin
                    used_next  = used_reg - GCW'(1);
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Working and response payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        gk_reg      <= gk_next;
        mk_reg      <= mk_next;
        g_reg       <= g_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        cnt_reg     <= cnt_next;
        key_cur_reg <= key_cur_next;
        status_reg  <= status_next;
        count_reg   <= count_next;
        if (rsp_load)
        begin
            // A count or purge with any hit reports success.
            if (((mode_reg == MODE_COUNT) || (mode_reg == MODE_PURGE)) && (count_reg != '0))
            begin
                rsp_status_reg <= ST_OK;
            end
            else
            begin
                rsp_status_reg <= status_reg;
            end
            rsp_count_reg <= count_reg;
        end
    end

endmodule

// File: src/tlmt_checker.sv
// Port-level checks of the membership table, bound to the top level.
module tlmt_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input tlmt_pkg::status_t       rsp_status,
    input tlmt_pkg::count_t        rsp_count
);
    import tlmt_pkg::*;

    // A stalled response keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
        else $error("stalled response changed");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // A nonzero count only comes with a success status.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_count != '0) |-> (rsp_status == ST_OK))
        else $error("count with failure status");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_NOT_FOUND) ||
                      (rsp_status == ST_TABLE_EMPTY) || (rsp_status == ST_LIST_EMPTY) ||
                      (rsp_status == ST_FULL))
        else $error("undefined status code");

endmodule

bind two_level_membership_table_top tlmt_checker u_tlmt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.match_count)
);

// File: sim/tb_two_level_membership_table_top.sv
// Self-checking testbench of the two-level membership table.
module tb_two_level_membership_table_top;
    import tlmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NGRP = 16;
    localparam int NMEM = 16;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    tlmt_req_if req_ch ();
    tlmt_rsp_if rsp_ch ();

    two_level_membership_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    typedef struct packed {
        status_t status;
        count_t  match_count;
    } answer_t;

    // Shadow copy of the table.
    key_t        grp_key [NGRP];
    int unsigned grp_cnt;
    key_t        mem_key [NGRP][NMEM];
    int unsigned mem_cnt [NGRP];

    answer_t answer_q[$];
    int      error_count;
    int      idle_cycles = 0;
    bit      rsp_idling;
    bit      req_idling;
    int      hold_off;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void remove_member(input int g, input int pos);
        for (int i = pos; i + 1 < mem_cnt[g]; i++)
            mem_key[g][i] = mem_key[g][i + 1];
        mem_cnt[g]--;
    endfunction

    // Predicts the answer to one request and updates the shadow table.
    function automatic answer_t table_answer(mode_t mode, key_t gk, key_t mk);
        answer_t a;
        int g;
        int i;
        int hits;
        bit decided;
        a.status = ST_NOT_FOUND;
        a.match_count = '0;
        hits = 0;
        decided = 1'b0;
        if (mode == MODE_ADD_GROUP)
        begin
            if (grp_cnt >= NGRP)
                a.status = ST_FULL;
            else
            begin
                grp_key[grp_cnt] = gk;
                mem_cnt[grp_cnt] = 0;
                grp_cnt++;
                a.status = ST_OK;
            end
        end
        else if (grp_cnt == 0)
            a.status = ST_TABLE_EMPTY;
        else if (mode == MODE_ADD_MEMBER || mode == MODE_FIND_GROUP || mode == MODE_DEL_GROUP)
        begin
            for (g = 0; g < grp_cnt; g++)
                if (grp_key[g] == gk)
                    break;
            if (g < grp_cnt)
            begin
                a.status = ST_OK;
                if (mode == MODE_ADD_MEMBER)
                begin
                    if (mem_cnt[g] >= NMEM)
                        a.status = ST_FULL;
                    else
                    begin
                        mem_key[g][mem_cnt[g]] = mk;
                        mem_cnt[g]++;
                    end
                end
                else if (mode == MODE_DEL_GROUP)
                begin
                    for (i = g; i + 1 < grp_cnt; i++)
                    begin
                        grp_key[i] = grp_key[i + 1];
                        mem_cnt[i] = mem_cnt[i + 1];
                        mem_key[i] = mem_key[i + 1];
                    end
                    mem_cnt[grp_cnt - 1] = 0;
                    grp_cnt--;
                end
            end
        end
        else if (mode == MODE_FIND_MEMBER || mode == MODE_DEL_MEMBER)
        begin
            for (g = 0; g < grp_cnt && !decided; g++)
            begin
                if (grp_key[g] != gk)
                    continue;
                if (mem_cnt[g] == 0)
                begin
                    a.status = ST_LIST_EMPTY;
                    decided = 1'b1;
                    break;
                end
                for (i = 0; i < mem_cnt[g]; i++)
                begin
                    if (mem_key[g][i] == mk)
                    begin
                        if (mode == MODE_DEL_MEMBER)
                            remove_member(g, i);
                        a.status = ST_OK;
                        decided = 1'b1;
                        break;
                    end
                end
            end
        end
        else
        begin
            // Count or purge across every group.
            for (g = 0; g < grp_cnt; g++)
            begin
                i = 0;
                while (i < mem_cnt[g])
                begin
                    if (mem_key[g][i] == mk)
                    begin
                        hits++;
                        if (mode == MODE_PURGE)
                        begin
                            remove_member(g, i);
                            continue;
                        end
                    end
                    i++;
                end
            end
            a.status = (hits > 0) ? ST_OK : ST_NOT_FOUND;
            a.match_count = (hits > 511) ? COUNT_MAX : count_t'(hits);
        end
        return a;
    endfunction

    // Sends one request, idling before it when allowed.
    task automatic send_request(input mode_t mode, input key_t gk, input key_t mk);
        if (req_idling && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.group_key  <= gk;
        req_ch.member_key <= mk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        answer_q.push_back(table_answer(mode, gk, mk));
    endtask

    // Response side: random stall bursts, plus a long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_off--;
            end
            else if (rsp_idling && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(posedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Response checker.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (answer_q.size() == 0)
                report_mismatch("unexpected response, status", rsp_ch.status, -1);
            else
            begin
                answer_t want;
                want = answer_q.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.match_count !== want.match_count)
                    report_mismatch("match_count", rsp_ch.match_count, want.match_count);
            end
        end
    end

    // Watchdog on cycles with no accepted request or response.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic key_t pick_key(input int spread);
        return (spread == 0) ? key_t'($urandom) : key_t'($urandom_range(0, spread));
    endfunction

    // Empty table, extremes of the keys and every mode.
    task automatic test_directed();
        mode_t m;
        for (int k = 0; k < 8; k++)
        begin
            m = mode_t'(k);
            send_request(m, 16'h0000, 16'hFFFF);
        end
        send_request(MODE_ADD_GROUP, 16'hFFFF, 16'h0000);
        send_request(MODE_ADD_GROUP, 16'h0000, 16'h0000);
        send_request(MODE_ADD_GROUP, 16'hFFFF, 16'h0000);
        send_request(MODE_FIND_MEMBER, 16'hFFFF, 16'h1234);
        send_request(MODE_ADD_MEMBER, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ADD_MEMBER, 16'h0000, 16'h0000);
        send_request(MODE_ADD_MEMBER, 16'hFFFF, 16'h0000);
        send_request(MODE_FIND_MEMBER, 16'hFFFF, 16'h0000);
        send_request(MODE_DEL_MEMBER, 16'h0000, 16'hFFFF);
        send_request(MODE_COUNT, 16'h5555, 16'h0000);
        send_request(MODE_PURGE, 16'hAAAA, 16'h0000);
        send_request(MODE_COUNT, 16'h0000, 16'h0000);
        send_request(MODE_FIND_GROUP, 16'h1111, 16'h0000);
        send_request(MODE_DEL_GROUP, 16'hFFFF, 16'h0000);
        send_request(MODE_DEL_GROUP, 16'h0000, 16'h0000);
        send_request(MODE_DEL_GROUP, 16'hFFFF, 16'h0000);
    endtask

    // Fills the group table and one member list past full, then empties them.
    task automatic test_full_tables();
        for (int k = 0; k < NGRP + 1; k++)
            send_request(MODE_ADD_GROUP, key_t'(k % 3), 16'h0);
        for (int k = 0; k < NMEM + 1; k++)
            send_request(MODE_ADD_MEMBER, 16'd1, key_t'(k % 2));
        send_request(MODE_COUNT, 16'd0, 16'd1);
        send_request(MODE_PURGE, 16'd0, 16'd1);
        for (int k = 0; k < NGRP; k++)
            send_request(MODE_DEL_GROUP, key_t'(k % 3), 16'h0);
    endtask

    // Random traffic with small key ranges so that lookups hit.
    task automatic test_random(input int count);
        int pick;
        mode_t m;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                m = MODE_ADD_GROUP;
            else if (pick < 45)
                m = MODE_ADD_MEMBER;
            else
                m = mode_t'($urandom_range(2, 7));
            if ($urandom_range(0, 9) == 0)
                send_request(m, pick_key(0), pick_key(0));
            else
                send_request(m, pick_key(5), pick_key(7));
        end
    endtask

    // Receiver holds off while requests keep coming.
    task automatic test_backpressure();
        hold_off = 300;
        test_random(20);
    endtask

    initial
    begin
        error_count = 0;
        hold_off = 0;
        rsp_idling = 1'b1;
        req_idling = 1'b1;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_ADD_GROUP;
        req_ch.group_key = '0;
        req_ch.member_key = '0;
        grp_cnt = 0;
        foreach (mem_cnt[g])
            mem_cnt[g] = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_tables();
        test_backpressure();
        test_random(350);
        rsp_idling = 1'b0;
        req_idling = 1'b0;
        test_random(100);
        req_ch.valid <= 1'b0;

        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: two_level_membership_table_top.f
src/tlmt_pkg.sv
src/tlmt_ifs.sv
src/two_level_membership_table_top.sv
src/tlmt_checker.sv
sim/tb_two_level_membership_table_top.sv
